// ===== hw/rtl/jse_pkg.sv =====
`timescale 1ns / 1ps
package jse_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChBackslash = 8'h5c;
	localparam logic [7:0] ChLowerU    = 8'h75;
	localparam logic [7:0] ChZero      = 8'h30;
	localparam logic [7:0] ChLowerA    = 8'h61;
	localparam logic [7:0] CtrlLimit   = 8'h20;
	localparam logic [7:0] NoEscape    = 8'h00;

	localparam logic [7:0] CodeBs  = 8'h08;
	localparam logic [7:0] CodeTab = 8'h09;
	localparam logic [7:0] CodeLf  = 8'h0a;
	localparam logic [7:0] CodeFf  = 8'h0c;
	localparam logic [7:0] CodeCr  = 8'h0d;

	localparam int unsigned MaxSeq = 8;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       starts_string;
		logic       ends_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// one request, fully expanded: bytes in order and index of the final byte
	typedef struct packed {
		logic [2:0]           last_idx;
		logic [MaxSeq-1:0][7:0] seq;
	} desc_t;

	function automatic logic [7:0] hex_lower(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = ChZero + {4'b0000, nib};
		end else begin
			r = ChLowerA + {4'b0000, nib} - 8'd10;
		end
		return r;
	endfunction

	// second character of a short escape, or NoEscape
	function automatic logic [7:0] short_escape(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			ChQuote:     r = ChQuote;
			ChBackslash: r = ChBackslash;
			CodeBs:      r = 8'h62;
			CodeFf:      r = 8'h66;
			CodeLf:      r = 8'h6e;
			CodeCr:      r = 8'h72;
			CodeTab:     r = 8'h74;
			default:     r = NoEscape;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/jse_front.sv =====
`timescale 1ns / 1ps
module jse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	output logic             src_stall,
	input  jse_pkg::in_item_t src_data,
	output logic             push,
	output jse_pkg::desc_t   push_data,
	input  logic             full
);

	logic [5:0][7:0] body;
	logic [2:0]      body_len;
	logic [7:0]      esc;
	logic [3:0]      pos;
	jse_pkg::desc_t  desc;
	logic            keep;
	logic            valid_s1;
	jse_pkg::desc_t  desc_s1;

	always_comb begin
		esc = jse_pkg::short_escape(src_data.byte_value);
		body = '0;
		body_len = 3'd0;
		if (src_data.has_byte) begin
			if (esc != jse_pkg::NoEscape) begin
				body[0] = jse_pkg::ChBackslash;
				body[1] = esc;
				body_len = 3'd2;
			end else if (src_data.byte_value < jse_pkg::CtrlLimit) begin
				body[0] = jse_pkg::ChBackslash;
				body[1] = jse_pkg::ChLowerU;
				body[2] = jse_pkg::ChZero;
				body[3] = jse_pkg::ChZero;
				body[4] = jse_pkg::hex_lower(src_data.byte_value[7:4]);
				body[5] = jse_pkg::hex_lower(src_data.byte_value[3:0]);
				body_len = 3'd6;
			end else begin
				body[0] = src_data.byte_value;
				body_len = 3'd1;
			end
		end
	end

	// place opening quote, body, closing quote
	always_comb begin
		desc = '0;
		pos = 4'd0;
		if (src_data.starts_string) begin
			desc.seq[0] = jse_pkg::ChQuote;
			pos = 4'd1;
		end
		for (int k = 0; k < 6; k++) begin
			if (3'(k) < body_len) begin
				desc.seq[pos[2:0]] = body[k];
				pos = pos + 4'd1;
			end
		end
		if (src_data.ends_string) begin
			desc.seq[pos[2:0]] = jse_pkg::ChQuote;
			pos = pos + 4'd1;
		end
		keep = (pos != 4'd0);
		desc.last_idx = pos[2:0] - 3'd1;
	end

	assign src_stall = valid_s1 && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			// drop requests that produce no bytes
			valid_s1 <= src_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			desc_s1 <= desc;
		end
	end

	assign push = valid_s1;
	assign push_data = desc_s1;

endmodule

// ===== hw/rtl/jse_queue.sv =====
`timescale 1ns / 1ps
module jse_queue #(
	parameter int unsigned DEPTH = jse_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jse_pkg::desc_t push_data,
	output logic           full,
	output logic           not_empty,
	output jse_pkg::desc_t head,
	input  logic           pop
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	jse_pkg::desc_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/jse_back.sv =====
`timescale 1ns / 1ps
module jse_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  jse_pkg::desc_t     head,
	output logic               pop,
	output logic               dst_valid,
	input  logic               dst_stall,
	output jse_pkg::out_item_t dst_data
);

	logic               have_q;
	jse_pkg::desc_t     desc_q;
	logic [2:0]         idx_q;
	logic               out_valid_q;
	jse_pkg::out_item_t out_q;
	logic               adv;
	logic               last;

	assign adv  = !out_valid_q || !dst_stall;
	assign last = (idx_q == desc_q.last_idx);
	// load the next request when idle or when the current one emits its last byte
	assign pop  = not_empty && (!have_q || (adv && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= have_q;
			end
			if (pop) begin
				have_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv && have_q) begin
				if (last) begin
					have_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= head;
		end
		if (adv && have_q) begin
			out_q.out_byte <= desc_q.seq[idx_q];
			out_q.run_last <= last;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule

// ===== hw/rtl/json_string_escaper_top.sv =====
`timescale 1ns / 1ps
// JSON string escaper.
// src channel: one request per source byte (src_data), with has_byte and
// string start/end flags. dst channel: one quoted/escaped byte per transfer;
// run_last marks the final byte produced by a request.
// Both channels complete a transfer at a clock edge with valid high and stall low.
// A request passes the front stage register, the queue and the back sequencer's
// request register before its first byte reaches the output register.
// The output stage emits one byte per cycle while the receiver is not stalling;
// a request expands to 0 to 8 bytes: a plain byte gives one, a short escape 2,
// a \u00XX escape 6, plus one per quote.
// The front classifies each request and expands it into a byte list, the
// queue (QUEUE_DEPTH entries) decouples it from the back sequencer, which
// walks the list one byte per cycle into the output register unless stalled.
// When the receiver stalls, the output register holds, the queue fills, and
// src_stall rises once the front stage cannot hand off its request.
// Reset clears the front stage, the queue and the output valid; requests
// in flight are lost, and none are produced across it.
module json_string_escaper_top #(
	parameter int unsigned QUEUE_DEPTH = jse_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  jse_pkg::in_item_t  src_data,
	output logic               dst_valid,
	input  logic               dst_stall,
	output jse_pkg::out_item_t dst_data
);

	logic           push;
	jse_pkg::desc_t push_data;
	logic           full;
	logic           not_empty;
	jse_pkg::desc_t head;
	logic           pop;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop)
	);

	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

// ===== tb/json_string_escaper_top_test.sv =====
`timescale 1ns / 1ps
module json_string_escaper_top_test;

	// Holds the quoted bytes still owed by the block, oldest first.
	class json_quote_tracker;
		jse_pkg::out_item_t quoted_bytes_due[$];

		function logic [7:0] nibble_char(logic [3:0] n);
			if (n < 4'd10) begin
				return jse_pkg::ChZero + {4'h0, n};
			end
			return jse_pkg::ChLowerA + {4'h0, n} - 8'd10;
		endfunction

		function void note_request(jse_pkg::in_item_t r);
			logic [7:0] seq[$];
			logic [7:0] esc;
			jse_pkg::out_item_t o;
			esc = jse_pkg::NoEscape;
			if (r.starts_string) begin
				seq.push_back(jse_pkg::ChQuote);
			end
			if (r.has_byte) begin
				case (r.byte_value)
					jse_pkg::ChQuote:     esc = jse_pkg::ChQuote;
					jse_pkg::ChBackslash: esc = jse_pkg::ChBackslash;
					jse_pkg::CodeBs:      esc = "b";
					jse_pkg::CodeFf:      esc = "f";
					jse_pkg::CodeLf:      esc = "n";
					jse_pkg::CodeCr:      esc = "r";
					jse_pkg::CodeTab:     esc = "t";
					default:              esc = jse_pkg::NoEscape;
				endcase
				if (esc != jse_pkg::NoEscape) begin
					seq.push_back(jse_pkg::ChBackslash);
					seq.push_back(esc);
				end else if (r.byte_value < jse_pkg::CtrlLimit) begin
					seq.push_back(jse_pkg::ChBackslash);
					seq.push_back(jse_pkg::ChLowerU);
					seq.push_back(jse_pkg::ChZero);
					seq.push_back(jse_pkg::ChZero);
					seq.push_back(nibble_char(r.byte_value[7:4]));
					seq.push_back(nibble_char(r.byte_value[3:0]));
				end else begin
					seq.push_back(r.byte_value);
				end
			end
			if (r.ends_string) begin
				seq.push_back(jse_pkg::ChQuote);
			end
			foreach (seq[k]) begin
				o.out_byte = seq[k];
				o.run_last = (k == seq.size() - 1);
				quoted_bytes_due.push_back(o);
			end
		endfunction

		// empty string when the result matches the oldest byte due
		function string check_result(jse_pkg::out_item_t got);
			jse_pkg::out_item_t want;
			string msg;
			msg = "";
			if (quoted_bytes_due.size() == 0) begin
				return $sformatf("unexpected byte %h run_last %b", got.out_byte, got.run_last);
			end
			want = quoted_bytes_due.pop_front();
			if (got.out_byte !== want.out_byte) begin
				msg = $sformatf("out_byte %h, want %h", got.out_byte, want.out_byte);
			end
			if (got.run_last !== want.run_last) begin
				msg = {msg, $sformatf(" run_last %b, want %b", got.run_last, want.run_last)};
			end
			return msg;
		endfunction

		function int outstanding();
			return quoted_bytes_due.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               src_valid;
	logic               src_stall;
	jse_pkg::in_item_t  src_data;
	logic               dst_valid;
	logic               dst_stall;
	jse_pkg::out_item_t dst_data;

	json_quote_tracker tracker;
	int mismatches;
	int requests_sent;
	int src_idle_pct;
	int dst_stall_pct;
	int hold_left;

	json_string_escaper_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		dst_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= ($urandom_range(99) < dst_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		string msg;
		if (arst_n && dst_valid && !dst_stall) begin
			msg = tracker.check_result(dst_data);
			if (msg != "") begin
				report_mismatch(msg);
			end
		end
	end

	task automatic send_request(jse_pkg::in_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
		@(negedge clk);
		src_valid <= 1'b1;
		src_data  <= it;
		@(posedge clk);
		while (src_stall) begin
			@(posedge clk);
		end
		tracker.note_request(it);
		if (it.has_byte || it.starts_string || it.ends_string) begin
			requests_sent++;
		end
	endtask

	task automatic send_fields(logic [7:0] b, logic has, logic st, logic en);
		jse_pkg::in_item_t it;
		it.byte_value    = b;
		it.has_byte      = has;
		it.starts_string = st;
		it.ends_string   = en;
		send_request(it);
	endtask

	// pause the sender until every byte owed has come out
	task automatic wait_for_results();
		@(negedge clk);
		src_valid <= 1'b0;
		while (tracker.outstanding() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] specials[7] = '{jse_pkg::ChQuote, jse_pkg::ChBackslash, jse_pkg::CodeBs,
			jse_pkg::CodeFf, jse_pkg::CodeLf, jse_pkg::CodeCr, jse_pkg::CodeTab};
		case ($urandom_range(9))
			0, 1:    return 8'($urandom_range(8'h1f));
			2:       return specials[$urandom_range(6)];
			3:       return 8'($urandom_range(8'hff, 8'h80));
			4:       return ($urandom_range(1) != 0) ? 8'h7f : 8'h20;
			default: return 8'($urandom_range(8'h7e, 8'h21));
		endcase
	endfunction

	task automatic send_string();
		int len;
		logic drop_start;
		logic drop_end;
		len = $urandom_range(12);
		drop_start = ($urandom_range(99) < 6);
		drop_end   = ($urandom_range(99) < 6);
		if (len == 0) begin
			send_fields(8'($urandom), 1'b0, !drop_start, !drop_end);
		end
		for (int k = 0; k < len; k++) begin
			// an occasional byte-less item inside the string
			if ($urandom_range(99) < 4) begin
				send_fields(8'($urandom), 1'b0, 1'b0, 1'b0);
			end
			send_fields(pick_byte(), 1'b1, (k == 0) && !drop_start, (k == len - 1) && !drop_end);
		end
	endtask

	task automatic run_phase(int src_pct, int dst_pct, int n_items);
		int target;
		src_idle_pct  = src_pct;
		dst_stall_pct = dst_pct;
		target = requests_sent + n_items;
		while (requests_sent < target) begin
			if ($urandom_range(99) < 15) begin
				send_fields(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				send_string();
			end
		end
		wait_for_results();
	endtask

	initial begin
		tracker       = new();
		mismatches    = 0;
		requests_sent = 0;
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		hold_left     = 0;
		arst_n        = 1'b0;
		src_valid     = 1'b0;
		src_data      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty string, nothing to emit, start or end alone
		send_fields(8'h41, 1'b0, 1'b1, 1'b1);
		send_fields(8'hff, 1'b0, 1'b0, 1'b0);
		send_fields(8'h00, 1'b0, 1'b1, 1'b0);
		send_fields(8'h00, 1'b0, 1'b0, 1'b1);
		// field extremes and pass-through edges
		send_fields(8'h00, 1'b1, 1'b1, 1'b0);
		send_fields(8'h1f, 1'b1, 1'b0, 1'b0);
		send_fields(8'h20, 1'b1, 1'b0, 1'b0);
		send_fields(8'h7f, 1'b1, 1'b0, 1'b0);
		send_fields(8'h80, 1'b1, 1'b0, 1'b0);
		send_fields(8'hff, 1'b1, 1'b0, 1'b1);
		// short escapes
		send_fields(jse_pkg::ChQuote, 1'b1, 1'b1, 1'b0);
		send_fields(jse_pkg::ChBackslash, 1'b1, 1'b0, 1'b0);
		send_fields(jse_pkg::CodeBs, 1'b1, 1'b0, 1'b0);
		send_fields(jse_pkg::CodeFf, 1'b1, 1'b0, 1'b0);
		send_fields(jse_pkg::CodeLf, 1'b1, 1'b0, 1'b0);
		send_fields(jse_pkg::CodeCr, 1'b1, 1'b0, 1'b0);
		send_fields(jse_pkg::CodeTab, 1'b1, 1'b0, 1'b1);
		// hex escapes, digits and letters, longest expansion
		send_fields(8'h01, 1'b1, 1'b1, 1'b0);
		send_fields(8'h1a, 1'b1, 1'b0, 1'b0);
		send_fields(8'h0b, 1'b1, 1'b0, 1'b1);
		send_fields(8'h1b, 1'b1, 1'b1, 1'b1);
		send_fields(8'h5a, 1'b1, 1'b1, 1'b1);
		wait_for_results();

		run_phase(0, 0, 70);
		run_phase(76, 0, 60);
		run_phase(0, 76, 60);
		run_phase(10, 10, 60);

		// long receiver hold-off with the sender pushing: fill the queue
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		hold_left     = 300;
		for (int k = 0; k < 40; k++) begin
			send_fields(8'($urandom_range(8'h1f)), 1'b1, 1'($urandom), 1'($urandom));
		end
		wait_for_results();

		run_phase(10, 10, 20);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && tracker.outstanding() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/jse_pkg.sv
hw/rtl/jse_front.sv
hw/rtl/jse_queue.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper_top.sv
tb/json_string_escaper_top_test.sv
